[rtl/c8is_pkg.sv]
// ----------------------------------------------------------------------------
// c8is_pkg
// shared types and constants of the instruction step core
// ----------------------------------------------------------------------------
package c8is_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_EXEC  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JUMP  = 4'h1;
  localparam logic [3:0] OP_SET   = 4'h6;
  localparam logic [3:0] OP_ADD   = 4'h7;
  localparam logic [3:0] OP_INDEX = 4'hA;
  localparam logic [3:0] OP_DRAW  = 4'hD;
  localparam logic [11:0] NNN_CLEAR = 12'h0E0;

  // controller to datapath
  typedef struct packed {
    logic mem_write;    // write input byte to memory
    logic mem_read_hi;  // read memory at pc
    logic mem_read_lo;  // read memory at pc+1
    logic mem_read_spr; // read memory at index+row count
    logic latch_hi;
    logic latch_lo;
    logic exec;         // execute non-draw opcode
    logic draw_start;   // clear vf, latch coordinates
    logic draw_row;     // apply latched sprite byte to one row
    logic clear_step;   // clear the whole display
    logic out_load;     // capture result
  } c8is_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       halted;
    logic       is_draw;
    logic       is_clear;
    logic       draw_last;  // this row is the final one
    logic       draw_empty; // height zero
    logic       mem_ready;  // memory clearing pass finished
  } c8is_stat_t;

endpackage

[rtl/c8is_datapath.sv]
// ----------------------------------------------------------------------------
// c8is_datapath
// memory, registers, display and output register of the core
// ----------------------------------------------------------------------------
module c8is_datapath
  import c8is_pkg::*;
#(
  parameter int MEM_BYTES       = 4096,
  parameter int DISPLAY_COLUMNS = 64,
  parameter int DISPLAY_ROWS    = 32,
  parameter int ENTRY_ADDRESS   = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  c8is_cmd_t   cmd,
  output c8is_stat_t  stat,
  input  logic [1:0]  mode,
  input  logic [11:0] load_address,
  input  logic [7:0]  data_byte,
  input  logic [4:0]  row_select,
  output logic [11:0] program_counter,
  output logic [11:0] index_value,
  output logic [7:0]  flag_register,
  output logic [15:0] opcode_seen,
  output logic [63:0] row_pixels,
  output logic        halted
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = (DISPLAY_ROWS > 1) ? $clog2(DISPLAY_ROWS) : 1;
  localparam int CW = (DISPLAY_COLUMNS > 1) ? $clog2(DISPLAY_COLUMNS) : 1;
  localparam int SW = DISPLAY_COLUMNS + 8;
  localparam int unsigned MEM_RECIP = (2**24 + MEM_BYTES - 1) / MEM_BYTES;
  localparam int unsigned ROW_RECIP = (2**24 + DISPLAY_ROWS - 1) / DISPLAY_ROWS;
  localparam int unsigned COL_RECIP = (2**24 + DISPLAY_COLUMNS - 1) / DISPLAY_COLUMNS;

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] mem_q;
  logic [AW:0] sweep;
  logic        mem_ready;

  logic [7:0] vreg [16];
  logic [DISPLAY_COLUMNS-1:0] disp [DISPLAY_ROWS];
  logic [DISPLAY_ROWS-1:0] disp_valid;

  logic [11:0] pc;
  logic [11:0] index;
  logic        halt;
  logic [15:0] op;
  logic [RW-1:0] cur_y;
  logic [CW-1:0] cur_x;
  logic [CW-1:0] x_use;
  logic [3:0]  row_cnt;

  logic [11:0] rd_addr12;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0] vx, vy;

  // remainder by a constant through a reciprocal multiply
  function automatic logic [11:0] mod_const(input logic [11:0] v, input int unsigned recip,
                                            input int unsigned divisor);
    logic [47:0] prod;
    logic [11:0] quo;
    prod = 48'(v) * 48'(recip);
    quo = prod[35:24];
    return v - 12'(32'(quo) * divisor);
  endfunction

  function automatic logic [AW-1:0] wrap(input logic [11:0] a);
    return AW'(mod_const(a, MEM_RECIP, MEM_BYTES));
  endfunction

  always_comb begin
    priority if (cmd.mem_read_hi) rd_addr12 = pc;
    else if (cmd.mem_read_lo) rd_addr12 = pc + 12'd1;
    else rd_addr12 = index + 12'(row_cnt);
    rd_addr = wrap(rd_addr12);
    wr_addr = wrap(load_address);
  end

  // clearing pass after reset, one address per cycle
  assign mem_ready = (sweep == (AW+1)'(MEM_BYTES));

  always_ff @(posedge clk) begin
    if (cmd.mem_write) mem[wr_addr] <= data_byte;
    else if (!mem_ready) mem[sweep[AW-1:0]] <= 8'd0;
    if (cmd.mem_read_hi || cmd.mem_read_lo || cmd.mem_read_spr) mem_q <= mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (rst) sweep <= '0;
    else if (!mem_ready) sweep <= sweep + 1'b1;
  end

  assign vx = vreg[op[11:8]];
  assign vy = vreg[op[7:4]];

  // x taken from vf follows collisions of earlier rows
  assign x_use = (op[11:8] == 4'hF) ? CW'(vreg[15][0]) : cur_x;

  logic [DISPLAY_COLUMNS-1:0] cur_row, spr_mask;
  logic [SW-1:0] spr_wide;
  assign cur_row = disp_valid[cur_y] ? disp[cur_y] : '0;
  always_comb begin
    spr_wide = {mem_q, {DISPLAY_COLUMNS{1'b0}}} >> x_use;
    spr_mask = spr_wide[SW-1 -: DISPLAY_COLUMNS];
  end

  logic [RW:0] y_next_full;
  assign y_next_full = {1'b0, cur_y} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 12'(ENTRY_ADDRESS);
      index <= '0;
      halt <= 1'b0;
      disp_valid <= '0;
      for (int i = 0; i < 16; i++) vreg[i] <= 8'd0;
    end else begin
      if (cmd.latch_hi) op[15:8] <= mem_q;
      if (cmd.latch_lo) begin
        op[7:0] <= mem_q;
        pc <= pc + 12'd2;
      end
      if (cmd.exec) begin
        unique case (op[15:12])
          OP_SYS:   if (op[11:0] != NNN_CLEAR) halt <= 1'b1;
          OP_JUMP:  pc <= op[11:0];
          OP_SET:   vreg[op[11:8]] <= op[7:0];
          OP_ADD:   vreg[op[11:8]] <= vx + op[7:0];
          OP_INDEX: index <= op[11:0];
          OP_DRAW:  ;
          default:  halt <= 1'b1;
        endcase
      end
      if (cmd.draw_start) begin
        vreg[15] <= 8'd0;
        row_cnt <= 4'd0;
        cur_y <= RW'(mod_const({4'd0, ((op[7:4] == 4'hF) ? 8'd0 : vy)},
                               ROW_RECIP, DISPLAY_ROWS));
        cur_x <= CW'(mod_const({4'd0, vx}, COL_RECIP, DISPLAY_COLUMNS));
      end
      if (cmd.draw_row) begin
        if (|(cur_row & spr_mask)) vreg[15] <= 8'd1;
        disp[cur_y] <= cur_row ^ spr_mask;
        disp_valid[cur_y] <= 1'b1;
        row_cnt <= row_cnt + 4'd1;
        cur_y <= y_next_full[RW-1:0];
      end
      if (cmd.clear_step) begin
        disp_valid <= '0;
      end
    end
  end

  assign stat.halted = halt;
  assign stat.is_draw = (op[15:12] == OP_DRAW);
  assign stat.is_clear = (op[15:12] == OP_SYS) && (op[11:0] == NNN_CLEAR);
  assign stat.draw_last = (row_cnt + 4'd1 == op[3:0]) ||
                          (y_next_full >= (RW+1)'(DISPLAY_ROWS));
  assign stat.draw_empty = (op[3:0] == 4'd0);
  assign stat.mem_ready = mem_ready;

  logic [DISPLAY_COLUMNS-1:0] sel_row;
  assign sel_row = (32'(row_select) < DISPLAY_ROWS && disp_valid[RW'(row_select)]) ?
                   disp[RW'(row_select)] : '0;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      program_counter <= pc;
      index_value <= index;
      flag_register <= vreg[15];
      halted <= halt;
      opcode_seen <= (mode == MODE_EXEC) ? op : 16'd0;
      row_pixels <= (mode == MODE_READ) ? (64'(sel_row) << (64 - DISPLAY_COLUMNS)) : 64'd0;
    end
  end

endmodule

[rtl/c8is_control.sv]
// ----------------------------------------------------------------------------
// c8is_control
// sequencer for write, execute and read items
// ----------------------------------------------------------------------------
module c8is_control
  import c8is_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  output logic       out_valid,
  input  logic       out_ready,
  input  c8is_stat_t stat,
  output c8is_cmd_t  cmd,
  output logic       exec_item
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HI    = 3'd1;
  localparam logic [2:0] S_LO    = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_SPR   = 3'd4;
  localparam logic [2:0] S_ROW   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       is_exec;

  assign in_ready = (state == S_IDLE) && stat.mem_ready && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        if (mode == MODE_EXEC && !stat.halted) begin
          cmd.mem_read_hi = 1'b1;
          state_next = S_HI;
        end else begin
          cmd.mem_write = (mode == MODE_WRITE);
          state_next = S_DONE;
        end
      end
      S_HI: begin
        cmd.latch_hi = 1'b1;
        cmd.mem_read_lo = 1'b1;
        state_next = S_LO;
      end
      S_LO: begin
        cmd.latch_lo = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.clear_step = stat.is_clear;
        if (stat.is_draw) begin
          cmd.draw_start = 1'b1;
          state_next = stat.draw_empty ? S_DONE : S_SPR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SPR: begin
        cmd.mem_read_spr = 1'b1;
        state_next = S_ROW;
      end
      S_ROW: begin
        cmd.draw_row = 1'b1;
        state_next = stat.draw_last ? S_DONE : S_SPR;
      end
      S_DONE: if (!out_valid || out_ready) begin
        cmd.out_load = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      is_exec <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      if (state == S_IDLE && in_valid && in_ready) is_exec <= (state_next == S_HI);
    end
  end

  assign exec_item = is_exec;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid) else $error("result lost");
  a_row_after_spr: assert property (@(posedge clk) disable iff (rst)
    cmd.draw_row |-> $past(cmd.mem_read_spr)) else $error("row without read");

endmodule

[rtl/chip8_instruction_step.sv]
// ----------------------------------------------------------------------------
// chip8_instruction_step
// instruction step core: memory load, one-instruction execute, row readback
// ----------------------------------------------------------------------------
// channel  | signals                                         | dir
// in       | in_valid in_ready mode load_address data_byte    | in
//          | row_select                                      |
// out      | out_valid out_ready program_counter index_value | out
//          | flag_register opcode_seen row_pixels halted     |
// write and read items go straight to the result; execute fetches both opcode bytes first
// draw then reads and applies one sprite row at a time; an execute item while halted skips the fetch
// after reset in_ready stays low while memory is cleared
// one item in flight; a stalled result holds the next item off
// ----------------------------------------------------------------------------
module chip8_instruction_step
  import c8is_pkg::*;
#(
  parameter int MEM_BYTES       = 4096,
  parameter int DISPLAY_COLUMNS = 64,
  parameter int DISPLAY_ROWS    = 32,
  parameter int ENTRY_ADDRESS   = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [11:0] load_address,
  input  logic [7:0]  data_byte,
  input  logic [4:0]  row_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] program_counter,
  output logic [11:0] index_value,
  output logic [7:0]  flag_register,
  output logic [15:0] opcode_seen,
  output logic [63:0] row_pixels,
  output logic        halted
);

  c8is_cmd_t  cmd;
  c8is_stat_t stat;
  logic       exec_item;
  logic [1:0] mode_q;
  logic [11:0] addr_q;
  logic [7:0] data_q;
  logic [4:0] row_q;
  logic [1:0] mode_use;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_q <= mode;
      addr_q <= load_address;
      data_q <= data_byte;
      row_q <= row_select;
    end
  end

  assign mode_use = exec_item ? MODE_EXEC : (mode_q == MODE_EXEC ? MODE_NONE : mode_q);

  c8is_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd),
    .exec_item(exec_item)
  );

  c8is_datapath #(
    .MEM_BYTES(MEM_BYTES), .DISPLAY_COLUMNS(DISPLAY_COLUMNS),
    .DISPLAY_ROWS(DISPLAY_ROWS), .ENTRY_ADDRESS(ENTRY_ADDRESS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .mode(cmd.mem_write ? mode : mode_use),
    .load_address(load_address), .data_byte(data_byte),
    .row_select(row_q), .program_counter(program_counter),
    .index_value(index_value), .flag_register(flag_register),
    .opcode_seen(opcode_seen), .row_pixels(row_pixels), .halted(halted)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(opcode_seen)) else $error("result dropped");

endmodule

[verif/tb_chip8_instruction_step.sv]
// ----------------------------------------------------------------------------
// tb_chip8_instruction_step
// The in channel is fed by a clocked driver that takes items from a queue.
// The queue is filled by generated programs: each instruction is written to
// memory at the predicted program counter and then executed, with random
// register, sprite and display traffic mixed in. A behavioral model of the
// core predicts every result. A clocked monitor checks each out transfer,
// field by field, against the oldest prediction. Halting opcodes run last.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_step;
  import c8is_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  mode;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [4:0]  row;
  } step_item_t;

  typedef struct {
    logic [11:0] pc;
    logic [11:0] idx;
    logic [7:0]  vf;
    logic [15:0] op;
    logic [63:0] pix;
    logic        halt;
  } step_result_t;

  localparam int STALL_LIMIT = 50000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = '0;
  logic [11:0] load_address = '0;
  logic [7:0]  data_byte = '0;
  logic [4:0]  row_select = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] program_counter;
  logic [11:0] index_value;
  logic [7:0]  flag_register;
  logic [15:0] opcode_seen;
  logic [63:0] row_pixels;
  logic        halted;

  step_item_t   pending_items[$];
  step_result_t expected_results[$];
  int           error_count = 0;
  int           idle_cycles = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  bit           gaps_on = 1'b1;
  int           issued = 0;

  // shadow of the core
  logic [7:0]  shadow_mem [4096];
  logic [7:0]  shadow_regs [16];
  logic [63:0] shadow_disp [32];
  logic [11:0] shadow_pc;
  logic [11:0] shadow_idx;
  logic        shadow_halt;

  chip8_instruction_step uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .load_address(load_address),
    .data_byte(data_byte), .row_select(row_select),
    .out_valid(out_valid), .out_ready(out_ready),
    .program_counter(program_counter), .index_value(index_value),
    .flag_register(flag_register), .opcode_seen(opcode_seen),
    .row_pixels(row_pixels), .halted(halted)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic draw_sprite(input logic [15:0] op);
    logic [3:0]  xr;
    logic [3:0]  yr;
    int          height;
    int          x;
    int          y;
    logic [7:0]  bits;
    logic [63:0] m;
    xr = op[11:8];
    yr = op[7:4];
    height = op[3:0];
    shadow_regs[15] = 8'd0;
    y = shadow_regs[yr] % 32;
    for (int n = 0; n < height; n++) begin
      x = shadow_regs[xr] % 64;
      bits = shadow_mem[(shadow_idx + n) & 12'hFFF];
      for (int b = 7; b >= 0; b--) begin
        if (bits[b]) begin
          m = 64'd1 << (63 - x);
          if ((shadow_disp[y] & m) != 0) shadow_regs[15] = 8'd1;
          shadow_disp[y] ^= m;
        end
        x++;
        if (x >= 64) break;
      end
      y++;
      if (y >= 32) break;
    end
  endtask

  task automatic predict_step(input step_item_t it, output step_result_t res);
    logic [15:0] op;
    logic [11:0] nnn;
    op = '0;
    res.pix = '0;
    case (it.mode)
      MODE_WRITE: shadow_mem[it.addr] = it.data;
      MODE_EXEC: begin
        if (!shadow_halt) begin
          op = {shadow_mem[shadow_pc], shadow_mem[shadow_pc + 12'd1]};
          shadow_pc = shadow_pc + 12'd2;
          nnn = op[11:0];
          case (op[15:12])
            OP_SYS: begin
              if (nnn == NNN_CLEAR) begin
                for (int r = 0; r < 32; r++) shadow_disp[r] = '0;
              end else begin
                shadow_halt = 1'b1;
              end
            end
            OP_JUMP:  shadow_pc = nnn;
            OP_SET:   shadow_regs[op[11:8]] = op[7:0];
            OP_ADD:   shadow_regs[op[11:8]] = shadow_regs[op[11:8]] + op[7:0];
            OP_INDEX: shadow_idx = nnn;
            OP_DRAW:  draw_sprite(op);
            default:  shadow_halt = 1'b1;
          endcase
        end
      end
      MODE_READ: res.pix = shadow_disp[it.row];
      default: ;
    endcase
    res.pc = shadow_pc;
    res.idx = shadow_idx;
    res.vf = shadow_regs[15];
    res.op = op;
    res.halt = shadow_halt;
  endtask

  task automatic issue(input logic [1:0] m, input logic [11:0] a, input logic [7:0] d,
                       input logic [4:0] r);
    step_item_t   it;
    step_result_t res;
    it.mode = m;
    it.addr = a;
    it.data = d;
    it.row = r;
    predict_step(it, res);
    pending_items.push_back(it);
    expected_results.push_back(res);
    issued++;
  endtask

  // place one instruction at the predicted pc and execute it
  task automatic run_op(input logic [15:0] op);
    issue(MODE_WRITE, shadow_pc, op[15:8], 5'($urandom));
    issue(MODE_WRITE, shadow_pc + 12'd1, op[7:0], 5'($urandom));
    issue(MODE_EXEC, 12'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic read_row(input logic [4:0] r);
    issue(MODE_READ, 12'($urandom), 8'($urandom), r);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] random_op();
    int k;
    k = $urandom_range(99);
    if (k < 3) return 16'h00E0;
    if (k < 10) return {OP_JUMP, 12'($urandom)};
    if (k < 35) return {OP_SET, 12'($urandom)};
    if (k < 55) return {OP_ADD, 12'($urandom)};
    if (k < 65) return {OP_INDEX, 12'($urandom)};
    return {OP_DRAW, 8'($urandom), 4'($urandom_range(0, 15))};
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    step_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        mode <= it.mode;
        load_address <= it.addr;
        data_byte <= it.data;
        row_select <= it.row;
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    step_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("transfer on out with no result pending");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (program_counter !== want.pc) report("program_counter", program_counter, want.pc);
          if (index_value !== want.idx) report("index_value", index_value, want.idx);
          if (flag_register !== want.vf) report("flag_register", flag_register, want.vf);
          if (opcode_seen !== want.op) report("opcode_seen", opcode_seen, want.op);
          if (row_pixels !== want.pix) report("row_pixels", row_pixels, want.pix);
          if (halted !== want.halt) report("halted", halted, want.halt);
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) recv_gap <= pick_gap();
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [3:0] bad;
    for (int i = 0; i < 4096; i++) shadow_mem[i] = '0;
    for (int i = 0; i < 16; i++) shadow_regs[i] = '0;
    for (int i = 0; i < 32; i++) shadow_disp[i] = '0;
    shadow_pc = 12'd512;
    shadow_idx = '0;
    shadow_halt = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed
    issue(MODE_WRITE, 12'hFFF, 8'hFF, 5'h1F);
    issue(MODE_WRITE, 12'h000, 8'hFF, 5'h00);
    issue(MODE_NONE, 12'hFFF, 8'hFF, 5'h1F);
    run_op({OP_SET, 4'h0, 8'hFF});
    run_op({OP_ADD, 4'h0, 8'h7D});
    run_op({OP_SET, 4'h1, 8'h3E});
    run_op({OP_INDEX, 12'hFFF});
    run_op({OP_DRAW, 4'h0, 4'h1, 4'hF});
    run_op({OP_DRAW, 4'h0, 4'h1, 4'hF});
    read_row(5'h1E);
    read_row(5'h1F);
    run_op({OP_DRAW, 4'hF, 4'hF, 4'h2});
    run_op({OP_DRAW, 4'h1, 4'h0, 4'h0});
    run_op(16'h00E0);
    read_row(5'h00);
    run_op({OP_JUMP, 12'hFFF});
    run_op({OP_JUMP, 12'hFFE});
    run_op({OP_JUMP, 12'h200});
    drain();

    // random programs
    while (issued < 720) begin
      gaps_on = ($urandom_range(3) != 0);
      repeat (20) begin
        case ($urandom_range(9))
          0: issue(MODE_WRITE, shadow_idx + 12'($urandom_range(15)), 8'($urandom), 5'($urandom));
          1: read_row(5'($urandom));
          2: if ($urandom_range(3) == 0) issue(MODE_NONE, 12'($urandom), 8'($urandom), 5'($urandom));
             else issue(MODE_WRITE, 12'($urandom), 8'($urandom), 5'($urandom));
          default: run_op(random_op());
        endcase
      end
      if ($urandom_range(9) == 0) drain();
    end
    drain();

    // halting opcodes run last since the flag is sticky
    gaps_on = 1'b1;
    do bad = 4'($urandom); while (bad inside {OP_JUMP, OP_SET, OP_ADD, OP_INDEX, OP_DRAW});
    if (bad == OP_SYS) run_op({OP_SYS, 12'h0E1});
    else run_op({bad, 12'($urandom)});
    run_op(16'h00E0);
    issue(MODE_EXEC, '0, '0, '0);
    read_row(5'($urandom));
    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/c8is_pkg.sv
rtl/c8is_datapath.sv
rtl/c8is_control.sv
rtl/chip8_instruction_step.sv
verif/tb_chip8_instruction_step.sv
